// ===== design/assert_macros.svh =====
// Assertion macros used by the top level for its concurrent checks.
// No dependencies; included by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPL(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |-> (cons)) \
		else $error("same-cycle implication check failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
	lbl: assert property (@(posedge clk_s) disable iff (!(rstn_s)) (ante) |=> (cons)) \
		else $error("next-cycle implication check failed");

`endif

// ===== design/mfir_pkg.sv =====
// Shared types and constants for the multichannel FIR filter.
// No dependencies; imported by the controller, the datapath and the top level.
package mfir_pkg;

	// Default sizing of the filter.
	localparam int DEF_TAPS     = 256;
	localparam int DEF_CHANNELS = 2;

	// Fixed field widths.
	localparam int VAL_W = 24;
	localparam int TC_W  = 9;
	localparam int TIX_W = 8;
	localparam int MODE_W = 2;

	// Reset value of the tap count register.
	localparam logic [TC_W-1:0] TC_RESET = 9'd256;

	// Item kinds.
	localparam logic [MODE_W-1:0] MODE_SAMPLE  = 2'd0;
	localparam logic [MODE_W-1:0] MODE_COEF    = 2'd1;
	localparam logic [MODE_W-1:0] MODE_RESTART = 2'd2;

	// Q1.23 saturation limits.
	localparam logic signed [VAL_W-1:0] Q_MAX = 24'sh7FFFFF;
	localparam logic signed [VAL_W-1:0] Q_MIN = 24'sh800000;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clear_step;
		logic accept;
		logic issue;
		logic out_load;
	} dp_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic clear_last;
		logic sample_start;
		logic run_empty;
		logic issue_last;
		logic pipe_busy;
		logic out_free;
	} dp_sts_t;

endpackage

// ===== design/mfir_ctrl.sv =====
// Controller state machine of the multichannel FIR filter.
// Depends on mfir_pkg for the command and status structs.
module mfir_ctrl import mfir_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  logic    in_valid,
	output logic    in_stall,
	input  dp_sts_t sts,
	output dp_cmd_t cmd
);

	typedef enum logic [4:0] {
		S_CLEAR  = 5'b00001,
		S_IDLE   = 5'b00010,
		S_RUN    = 5'b00100,
		S_DRAIN  = 5'b01000,
		S_FINISH = 5'b10000
	} state_t;

	state_t state_q;
	state_t state_d;

	// Next state and command decode.
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		unique case (state_q)
			S_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					state_d = S_IDLE;
				end
			end
			S_IDLE: begin
				cmd.accept = in_valid;
				if (in_valid && sts.sample_start) begin
					state_d = sts.run_empty ? S_FINISH : S_RUN;
				end
			end
			S_RUN: begin
				cmd.issue = 1'b1;
				if (sts.issue_last) begin
					state_d = S_DRAIN;
				end
			end
			S_DRAIN: begin
				if (!sts.pipe_busy) begin
					state_d = S_FINISH;
				end
			end
			S_FINISH: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// Items are taken only while idle.
	assign in_stall = (state_q != S_IDLE);

	// State register; reset starts the coefficient clearing pass.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

endmodule

// ===== design/mfir_dp.sv =====
// Datapath of the multichannel FIR filter: memories, pointers, MAC, rounding, output.
// Depends on mfir_pkg for widths, codes and the command and status structs.
module mfir_dp import mfir_pkg::*; #(
	parameter int TAPS     = DEF_TAPS,
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [TC_W-1:0]         cfg_wdata,
	input  logic [MODE_W-1:0]       mode,
	input  logic                    channel,
	input  logic [TIX_W-1:0]        tap_index,
	input  logic signed [VAL_W-1:0] value,
	input  logic                    out_stall,
	output logic                    out_valid,
	output logic                    out_channel,
	output logic signed [VAL_W-1:0] filtered,
	output logic                    clipped,
	input  dp_cmd_t                 cmd,
	output dp_sts_t                 sts
);

	localparam int TAP_W  = $clog2(TAPS);
	localparam int CH_W   = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam int A_W    = CH_W + TAP_W;
	localparam int DEPTH  = 1 << A_W;
	localparam int FILL_W = $clog2(TAPS + 1);
	localparam int N_W    = (FILL_W > TC_W) ? FILL_W : TC_W;
	localparam int PROD_W = 2 * VAL_W;
	localparam int ACC_W  = PROD_W + TAP_W;
	localparam int RND_W  = ACC_W - 23;

	// Sample history and coefficient memories, one row of 2**TAP_W per channel.
	logic signed [VAL_W-1:0] hist_mem [DEPTH];
	logic signed [VAL_W-1:0] coef_mem [DEPTH];

	// Per-channel newest slot and count of samples since restart, capped at TAPS.
	logic [TAP_W-1:0]  pos_q  [CHANNELS];
	logic [FILL_W-1:0] fill_q [CHANNELS];

	logic [TC_W-1:0]   tap_count_q;
	logic [A_W-1:0]    clr_addr_q;
	logic [CH_W-1:0]   run_ch_q;
	logic [TAP_W-1:0]  rp_q;
	logic [TAP_W-1:0]  k_q;
	logic [FILL_W-1:0] rem_q;

	logic                     v_s1;
	logic                     v_s2;
	logic signed [VAL_W-1:0]  hist_s1;
	logic signed [VAL_W-1:0]  coef_s1;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	logic                    out_valid_q;
	logic                    out_channel_q;
	logic signed [VAL_W-1:0] filtered_q;
	logic                    clipped_q;

	logic [CH_W-1:0]   ch_idx;
	logic              ch_ok;
	logic              tix_ok;
	logic [TAP_W-1:0]  pos_cur;
	logic [TAP_W-1:0]  pos_new;
	logic [FILL_W-1:0] fill_cur;
	logic [FILL_W-1:0] fill_new;
	logic [N_W-1:0]    tc_limit;
	logic [N_W-1:0]    run_len;
	logic              do_sample;
	logic              do_coef;
	logic              do_restart;

	logic signed [ACC_W-1:0] acc_rnd;
	logic signed [RND_W-1:0] rnd;
	logic                    ovf;
	logic signed [VAL_W-1:0] sat_val;

	// Decode of the item on the input port.
	always_comb begin
		ch_idx     = CH_W'(channel);
		ch_ok      = (32'(channel) < CHANNELS);
		tix_ok     = (32'(tap_index) < TAPS);
		pos_cur    = pos_q[ch_idx];
		fill_cur   = fill_q[ch_idx];
		pos_new    = (pos_cur == TAP_W'(TAPS - 1)) ? '0 : pos_cur + TAP_W'(1);
		fill_new   = (fill_cur == FILL_W'(TAPS)) ? fill_cur : fill_cur + FILL_W'(1);
		tc_limit   = (N_W'(tap_count_q) > N_W'(TAPS)) ? N_W'(TAPS) : N_W'(tap_count_q);
		run_len    = (tc_limit < N_W'(fill_new)) ? tc_limit : N_W'(fill_new);
		do_sample  = cmd.accept && (mode == MODE_SAMPLE) && ch_ok;
		do_coef    = cmd.accept && (mode == MODE_COEF) && ch_ok && tix_ok;
		do_restart = cmd.accept && (mode == MODE_RESTART);
	end

	// Status to the controller.
	always_comb begin
		sts.clear_last   = &clr_addr_q;
		sts.sample_start = (mode == MODE_SAMPLE) && ch_ok;
		sts.run_empty    = (tap_count_q == '0);
		sts.issue_last   = (rem_q == FILL_W'(1));
		sts.pipe_busy    = v_s1 || v_s2;
		sts.out_free     = !out_valid_q || !out_stall;
	end

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tap_count_q <= TC_RESET;
		end else if (cfg_we) begin
			tap_count_q <= cfg_wdata;
		end
	end

	// Per-channel pointers; a restart empties every history at once.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i]  <= '0;
				fill_q[i] <= '0;
			end
		end else if (do_restart) begin
			for (int i = 0; i < CHANNELS; i++) begin
				pos_q[i]  <= '0;
				fill_q[i] <= '0;
			end
		end else if (do_sample) begin
			pos_q[ch_idx]  <= pos_new;
			fill_q[ch_idx] <= fill_new;
		end
	end

	// Clearing pass address and tap sequencing counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_addr_q <= '0;
			run_ch_q   <= '0;
			rp_q       <= '0;
			k_q        <= '0;
			rem_q      <= '0;
		end else begin
			if (cmd.clear_step) begin
				clr_addr_q <= clr_addr_q + A_W'(1);
			end
			if (do_sample) begin
				run_ch_q <= ch_idx;
				rp_q     <= pos_new;
				k_q      <= '0;
				rem_q    <= FILL_W'(run_len);
			end else if (cmd.issue) begin
				rp_q  <= (rp_q == '0) ? TAP_W'(TAPS - 1) : rp_q - TAP_W'(1);
				k_q   <= k_q + TAP_W'(1);
				rem_q <= rem_q - FILL_W'(1);
			end
		end
	end

	// History memory: written with each sample, read once per tap.
	always_ff @(posedge clk) begin
		if (do_sample) begin
			hist_mem[{ch_idx, pos_new}] <= value;
		end
		if (cmd.issue) begin
			hist_s1 <= hist_mem[{run_ch_q, rp_q}];
		end
	end

	// Coefficient memory: cleared after reset, written by coefficient items.
	always_ff @(posedge clk) begin
		if (cmd.clear_step) begin
			coef_mem[clr_addr_q] <= '0;
		end else if (do_coef) begin
			coef_mem[{ch_idx, TAP_W'(tap_index)}] <= value;
		end
		if (cmd.issue) begin
			coef_s1 <= coef_mem[{run_ch_q, k_q}];
		end
	end

	// Valid bits of the multiply-accumulate pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
		end else begin
			v_s1 <= cmd.issue;
			v_s2 <= v_s1;
		end
	end

	// Product stage and wide accumulator.
	always_ff @(posedge clk) begin
		prod_s2 <= hist_s1 * coef_s1;
		if (do_sample) begin
			acc_q <= '0;
		end else if (v_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	// Round half up to Q1.23 and saturate to 24 bits.
	always_comb begin
		acc_rnd = acc_q + ACC_W'(32'sd4194304);
		rnd     = acc_rnd[ACC_W-1:23];
		ovf     = !((&rnd[RND_W-1:VAL_W-1]) || !(|rnd[RND_W-1:VAL_W-1]));
		if (ovf) begin
			sat_val = rnd[RND_W-1] ? Q_MIN : Q_MAX;
		end else begin
			sat_val = rnd[VAL_W-1:0];
		end
	end

	// Output register; holds a finished item until it is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_channel_q <= run_ch_q[0];
			filtered_q    <= sat_val;
			clipped_q     <= ovf;
		end
	end

	assign out_valid   = out_valid_q;
	assign out_channel = out_channel_q;
	assign filtered    = filtered_q;
	assign clipped     = clipped_q;

endmodule

// ===== design/multichannel_fir_filter.sv =====
// Top level of the multichannel FIR filter: controller plus datapath.
// Depends on mfir_pkg, mfir_ctrl, mfir_dp and assert_macros.svh.

// Direct-form FIR filter with one impulse response per channel, Q1.23 in and out.
// An item is a coefficient write (mode 1), a restart that empties every channel's
// history (mode 2), or an audio sample (mode 0) that yields one filtered item.
// Coefficient writes, restarts and unused modes leave the controller idle, ready for
// the next item. A sample runs n taps before the block takes its next item, where n
// is the smallest of tap_count, TAPS and the number of samples seen on that channel
// since the last restart, this one included. The taps run one multiply-accumulate
// per tap through the single shared multiplier, fed by one read port on each memory.
// Then the read, product and accumulate stages drain and the result is rounded and
// loaded into the output register. With tap_count at zero no taps run and the sample
// goes straight to the load. The load waits while a previous item still sits stalled
// in the output register. After reset the coefficient memory is cleared, one entry
// per cycle, over all 2**(CH_W + TAP_W) entries (512 at the defaults), CH_W being
// clog2(CHANNELS) but at least 1; in_stall stays high during that pass while tap_count
// writes are still taken. A finished item waits in the output register until taken.
`include "assert_macros.svh"

module multichannel_fir_filter import mfir_pkg::*; #(
	parameter int TAPS     = DEF_TAPS,
	parameter int CHANNELS = DEF_CHANNELS
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_we,
	input  logic [TC_W-1:0]         cfg_wdata,
	input  logic                    in_valid,
	output logic                    in_stall,
	input  logic [MODE_W-1:0]       mode,
	input  logic                    channel,
	input  logic [TIX_W-1:0]        tap_index,
	input  logic signed [VAL_W-1:0] value,
	output logic                    out_valid,
	input  logic                    out_stall,
	output logic                    out_channel,
	output logic signed [VAL_W-1:0] filtered,
	output logic                    clipped
);

	dp_cmd_t cmd;
	dp_sts_t sts;

	// Sequencing of clear pass, item intake, tap loop and result load.
	mfir_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// Memories, multiply-accumulate and output register.
	mfir_dp #(
		.TAPS     (TAPS),
		.CHANNELS (CHANNELS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.mode        (mode),
		.channel     (channel),
		.tap_index   (tap_index),
		.value       (value),
		.out_stall   (out_stall),
		.out_valid   (out_valid),
		.out_channel (out_channel),
		.filtered    (filtered),
		.clipped     (clipped),
		.cmd         (cmd),
		.sts         (sts)
	);

	// A new item never arrives while products are still in flight.
	`ASSERT_IMPL(a_accept_drained, clk, arst_n, cmd.accept, !sts.pipe_busy)
	// A result is loaded only into a free output slot.
	`ASSERT_IMPL(a_load_free, clk, arst_n, cmd.out_load, sts.out_free)
	// A loaded result shows up on the output in the next cycle.
	`ASSERT_NEXT(a_load_shows, clk, arst_n, cmd.out_load, out_valid)
	// The input side stays stalled during the clearing pass.
	`ASSERT_IMPL(a_clear_stalls, clk, arst_n, cmd.clear_step, in_stall)

endmodule
